### design/pce_pkg.sv
// types, constants and bit-reversal helpers for the parametric crc engine
`default_nettype none

package pce_pkg;

  localparam int unsigned CrcMaxW  = 64;
  localparam int unsigned CrcMinW  = 8;
  localparam int unsigned CfgWidW  = 7;
  localparam int unsigned ShamtW   = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegCrcWidth    = 3'd0,
    RegPolynomial  = 3'd1,
    RegInitValue   = 3'd2,
    RegFinalXor    = 3'd3,
    RegReflectIn   = 3'd4,
    RegReflectOut  = 3'd5
  } cfg_reg_e;

  localparam logic [CfgWidW-1:0] RstCrcWidth   = 7'd16;
  localparam logic [CrcMaxW-1:0] RstPolynomial = 64'h0000_0000_0000_1021;
  localparam logic [CrcMaxW-1:0] RstInitValue  = '0;
  localparam logic [CrcMaxW-1:0] RstFinalXor   = '0;

  typedef logic [CrcMaxW-1:0] crc_t;

  function automatic logic [ByteW-1:0] rev8(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = v[ByteW-1-i];
    end
    return r;
  endfunction

  function automatic crc_t rev64(input crc_t v);
    crc_t r;
    for (int i = 0; i < CrcMaxW; i++) begin
      r[i] = v[CrcMaxW-1-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/parametric_crc_engine_core.sv
// top level of the parametric crc engine: byte-wide crc update with configurable width
`default_nettype none

// Byte-wide CRC engine, MSB-first register, width 8 to 64 bits. One byte is taken
// per cycle while the input is not stalled: a byte waits in the input register,
// then the eight-bit division step (carried left-aligned in 64 bits so the feedback
// tap is always bit 63) is computed combinationally and the running CRC is updated.
// The word marked with tlast passes the input register and its finished CRC is
// loaded into the result register; it waits there until taken, and input stalls
// only when a further last word finds that register still full. Configuration
// writes go to the configuration registers; derived masks and aligned operands are
// recomputed from them in registers each cycle.
module parametric_crc_engine_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [pce_pkg::ByteW-1:0]       s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic                            s_axis_tlast_i,   // last_byte
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [pce_pkg::CrcMaxW-1:0]          m_axis_tdata_o,   // [63:0] crc_value
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [pce_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [pce_pkg::CrcMaxW-1:0]     cfg_data_i
);

  // configuration registers
  logic [pce_pkg::CfgWidW-1:0] crc_width_q;
  pce_pkg::crc_t               poly_q;
  pce_pkg::crc_t               init_q;
  pce_pkg::crc_t               fxor_q;
  logic                        refl_in_q;
  logic                        refl_out_q;

  // derived operands
  logic [pce_pkg::ShamtW-1:0]  shamt_d, shamt_q;
  pce_pkg::crc_t               mask_d, mask_q;
  pce_pkg::crc_t               poly_al_d, poly_al_q;
  pce_pkg::crc_t               init_al_d, init_al_q;

  // input register
  logic                        in_valid_q;
  logic [pce_pkg::ByteW-1:0]   in_byte_q;
  logic                        in_last_q;

  // running state
  logic                        in_msg_q;
  pce_pkg::crc_t               run_d, run_q;

  // result register
  logic                        out_valid_q;
  pce_pkg::crc_t               out_crc_d, out_crc_q;

  logic                        consume;
  pce_pkg::crc_t               crc_al;

  // config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_width_q <= pce_pkg::RstCrcWidth;
      poly_q      <= pce_pkg::RstPolynomial;
      init_q      <= pce_pkg::RstInitValue;
      fxor_q      <= pce_pkg::RstFinalXor;
      refl_in_q   <= 1'b0;
      refl_out_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pce_pkg::RegCrcWidth:   crc_width_q <= cfg_data_i[pce_pkg::CfgWidW-1:0];
        pce_pkg::RegPolynomial: poly_q      <= cfg_data_i;
        pce_pkg::RegInitValue:  init_q      <= cfg_data_i;
        pce_pkg::RegFinalXor:   fxor_q      <= cfg_data_i;
        pce_pkg::RegReflectIn:  refl_in_q   <= cfg_data_i[0];
        pce_pkg::RegReflectOut: refl_out_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp width, build mask and left-aligned operands
  always_comb begin
    logic [pce_pkg::CfgWidW-1:0] w_eff;
    logic [pce_pkg::CfgWidW-1:0] gap;
    if (crc_width_q < pce_pkg::CfgWidW'(pce_pkg::CrcMinW)) begin
      w_eff = pce_pkg::CfgWidW'(pce_pkg::CrcMinW);
    end else if (crc_width_q > pce_pkg::CfgWidW'(pce_pkg::CrcMaxW)) begin
      w_eff = pce_pkg::CfgWidW'(pce_pkg::CrcMaxW);
    end else begin
      w_eff = crc_width_q;
    end
    gap       = pce_pkg::CfgWidW'(pce_pkg::CrcMaxW) - w_eff;
    shamt_d   = gap[pce_pkg::ShamtW-1:0];
    mask_d    = {pce_pkg::CrcMaxW{1'b1}} >> shamt_d;
    poly_al_d = (poly_q & mask_d) << shamt_d;
    init_al_d = (init_q & mask_d) << shamt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shamt_q   <= pce_pkg::ShamtW'(pce_pkg::CrcMaxW - 16);
      mask_q    <= 64'h0000_0000_0000_ffff;
      poly_al_q <= pce_pkg::RstPolynomial << (pce_pkg::CrcMaxW - 16);
      init_al_q <= '0;
    end else begin
      shamt_q   <= shamt_d;
      mask_q    <= mask_d;
      poly_al_q <= poly_al_d;
      init_al_q <= init_al_d;
    end
  end

  // handshake
  assign consume         = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // byte update, msb first on the left-aligned register
  always_comb begin
    logic [pce_pkg::ByteW-1:0] dbyte;
    logic                      top;
    pce_pkg::crc_t             fin;
    dbyte  = refl_in_q ? pce_pkg::rev8(in_byte_q) : in_byte_q;
    crc_al = in_msg_q ? ((run_q & mask_q) << shamt_q) : init_al_q;
    for (int b = 0; b < pce_pkg::ByteW; b++) begin
      top    = crc_al[pce_pkg::CrcMaxW-1] ^ dbyte[pce_pkg::ByteW-1-b];
      crc_al = crc_al << 1;
      if (top) begin
        crc_al = crc_al ^ poly_al_q;
      end
    end
    run_d     = crc_al >> shamt_q;
    fin       = refl_out_q ? pce_pkg::rev64(crc_al) : run_d;
    out_crc_d = (fin ^ fxor_q) & mask_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      run_q    <= '0;
    end else if (consume) begin
      in_msg_q <= !in_last_q;
      run_q    <= in_last_q ? '0 : run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_last_q) begin
      out_crc_q <= out_crc_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_crc_q;

  // checks
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(consume && in_last_q))
    else $error("result without a last word");

  a_msg_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_last_q) |=> (!in_msg_q && run_q == '0))
    else $error("message state not cleared after last word");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_last_q && out_valid_q && !m_axis_tready_i)
      |=> (in_valid_q && in_last_q && $stable(in_byte_q)))
    else $error("pending last word lost while result stalled");

  a_shamt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shamt_q <= pce_pkg::ShamtW'(pce_pkg::CrcMaxW - pce_pkg::CrcMinW))
    else $error("alignment shift out of range");

endmodule

`default_nettype wire

### tb/parametric_crc_engine_core_tb.sv
// self-checking testbench for the parametric crc engine core: byte stream in, crc words out
`timescale 1ns / 1ps

module parametric_crc_engine_core_tb;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned PhaseBytes   = 106;
  localparam logic [pce_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [pce_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [pce_pkg::ByteW-1:0] data;
    logic                      last;
  } msg_byte_t;

  logic                        clk_i    = 1'b0;
  logic                        rst_ni   = 1'b0;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [pce_pkg::ByteW-1:0]   s_tdata  = '0;
  logic                        s_tlast  = 1'b0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  pce_pkg::crc_t               m_tdata;
  logic                        cfg_we   = 1'b0;
  logic [pce_pkg::CfgIdxW-1:0] cfg_idx  = '0;
  pce_pkg::crc_t               cfg_data = '0;

  // crc predictor state and its copy of the registers
  logic [pce_pkg::CfgWidW-1:0] width_reg  = pce_pkg::RstCrcWidth;
  pce_pkg::crc_t               poly_reg   = pce_pkg::RstPolynomial;
  pce_pkg::crc_t               init_reg   = pce_pkg::RstInitValue;
  pce_pkg::crc_t               xorout_reg = pce_pkg::RstFinalXor;
  logic                        refin_reg  = 1'b0;
  logic                        refout_reg = 1'b0;
  pce_pkg::crc_t               crc_acc    = '0;
  logic                        msg_open   = 1'b0;

  msg_byte_t     byte_pending[$];
  pce_pkg::crc_t crc_expected[$];
  int unsigned   bytes_queued   = 0;
  int unsigned   bytes_taken    = 0;
  int unsigned   errors         = 0;
  int unsigned   cycles         = 0;
  int unsigned   src_idle_pct   = 0;
  int unsigned   sink_stall_pct = 0;

  parametric_crc_engine_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned crc_span();
    if (width_reg < pce_pkg::CrcMinW) return pce_pkg::CrcMinW;
    if (width_reg > pce_pkg::CrcMaxW) return pce_pkg::CrcMaxW;
    return width_reg;
  endfunction

  function automatic pce_pkg::crc_t mirror(input pce_pkg::crc_t v, input int unsigned n);
    pce_pkg::crc_t r;
    r = '0;
    for (int k = 0; k < n; k++) begin
      r[n-1-k] = v[k];
    end
    return r;
  endfunction

  function automatic pce_pkg::crc_t rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic pce_pkg::crc_t pick_operand();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // fold one accepted word into the running crc, queue the finished crc on a last word
  task automatic fold_byte(input logic [pce_pkg::ByteW-1:0] data, input logic last);
    int unsigned               span;
    pce_pkg::crc_t             mask;
    pce_pkg::crc_t             poly;
    pce_pkg::crc_t             crc;
    pce_pkg::crc_t             flipped;
    logic [pce_pkg::ByteW-1:0] b;
    logic                      top;
    span = crc_span();
    mask = (span >= pce_pkg::CrcMaxW) ? '1 : ((pce_pkg::crc_t'(1) << span) - 1);
    poly = poly_reg & mask;
    crc = (msg_open ? crc_acc : init_reg) & mask;
    flipped = mirror(pce_pkg::crc_t'(data), pce_pkg::ByteW);
    b = refin_reg ? flipped[pce_pkg::ByteW-1:0] : data;
    for (int k = 0; k < pce_pkg::ByteW; k++) begin
      top = crc[span-1] ^ b[pce_pkg::ByteW-1-k];
      crc = (crc << 1) & mask;
      if (top) begin
        crc = crc ^ poly;
      end
    end
    if (last) begin
      if (refout_reg) begin
        crc = mirror(crc, span);
      end
      crc_expected.push_back((crc ^ xorout_reg) & mask);
      crc_acc = '0;
      msg_open = 1'b0;
    end else begin
      crc_acc = crc;
      msg_open = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin : drv
    msg_byte_t nxt;
    if (rst_ni && (!s_tvalid || s_tready)) begin
      if (byte_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = byte_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= nxt.data;
        s_tlast <= nxt.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : mon
    pce_pkg::crc_t want;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        fold_byte(s_tdata, s_tlast);
        bytes_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (crc_expected.size() == 0) begin
          $display("%0t: crc word with none expected: expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = crc_expected.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: crc_value mismatch: expected %h, actual %h", $time, want, m_tdata);
            errors++;
          end
        end
      end
    end
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [pce_pkg::CfgIdxW-1:0] idx, input pce_pkg::crc_t value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    case (idx)
      pce_pkg::RegCrcWidth:   width_reg = value[pce_pkg::CfgWidW-1:0];
      pce_pkg::RegPolynomial: poly_reg = value;
      pce_pkg::RegInitValue:  init_reg = value;
      pce_pkg::RegFinalXor:   xorout_reg = value;
      pce_pkg::RegReflectIn:  refin_reg = value[0];
      pce_pkg::RegReflectOut: refout_reg = value[0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(input pce_pkg::crc_t width, input pce_pkg::crc_t poly,
                         input pce_pkg::crc_t init, input pce_pkg::crc_t xorout,
                         input pce_pkg::crc_t refin, input pce_pkg::crc_t refout);
    write_reg(pce_pkg::RegCrcWidth, width);
    write_reg(pce_pkg::RegPolynomial, poly);
    write_reg(pce_pkg::RegInitValue, init);
    write_reg(pce_pkg::RegFinalXor, xorout);
    write_reg(pce_pkg::RegReflectIn, refin);
    write_reg(pce_pkg::RegReflectOut, refout);
    write_reg(RegSpareLo, rand64());
    write_reg(RegSpareHi, rand64());
    cfg_we <= 1'b0;
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic randomise_cfg();
    pce_pkg::crc_t wsel;
    pce_pkg::crc_t junk;
    case ($urandom_range(7))
      0: wsel = pce_pkg::CrcMinW;
      1: wsel = pce_pkg::CrcMaxW;
      2: wsel = $urandom_range(pce_pkg::CrcMinW - 1, 0);
      3: wsel = $urandom_range(127, pce_pkg::CrcMaxW + 1);
      default: wsel = $urandom_range(pce_pkg::CrcMaxW, pce_pkg::CrcMinW);
    endcase
    // stray upper bits must not matter
    if ($urandom_range(3) == 0) begin
      junk = rand64();
      wsel[pce_pkg::CrcMaxW-1:pce_pkg::CfgWidW] = junk[pce_pkg::CrcMaxW-1:pce_pkg::CfgWidW];
    end
    set_cfg(wsel, pick_operand(), pick_operand(), pick_operand(), rand64(), rand64());
  endtask

  task automatic push_byte(input logic [pce_pkg::ByteW-1:0] data, input logic last);
    byte_pending.push_back({data, last});
    bytes_queued++;
  endtask

  task automatic drain();
    while (bytes_taken != bytes_queued || crc_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned left;
    int unsigned len;
    logic        open_tail;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    randomise_cfg();
    left = PhaseBytes;
    while (left != 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(48, 9) : $urandom_range(8, 1);
      if (len > left) len = left;
      left -= len;
      // a phase may stop mid-message so the next settings apply to an open crc
      open_tail = (left == 0) && ($urandom_range(3) == 0);
      for (int k = 0; k < len; k++) begin
        push_byte(pce_pkg::ByteW'($urandom_range(255)), (k == len - 1) && !open_tail);
      end
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 16-bit xmodem check string, then the byte extremes
    for (int k = 0; k < 9; k++) begin
      push_byte(pce_pkg::ByteW'(8'h31 + k), k == 8);
    end
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    drain();

    // 32-bit reflected crc, message left open
    set_cfg(32, 64'h0000_0000_04C1_1DB7, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
            1, 1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    drain();

    // full width via a value with stray upper bits, all-ones polynomial and init value
    set_cfg(64'hFFFF_FFFF_FFFF_FFC0, '1, '1, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b1);
    drain();

    // width below range clamps to 8, wide operands
    set_cfg(0, 64'hFFFF_FFFF_FFFF_FF07, '1, '1, 1, 0);
    push_byte(8'hFF, 1'b0);
    drain();

    // width above range clamps to 64, change lands mid-message
    set_cfg(127, 64'h42F0_E1EB_A9EA_3693, '0, '0, 0, 0);
    push_byte(8'h5A, 1'b1);
    push_byte(8'h00, 1'b1);
    drain();

    run_phase(0, 0);
    run_phase(47, 0);
    run_phase(0, 47);
    run_phase(8, 8);
    run_phase(0, 0);
    run_phase(47, 0);
    run_phase(0, 47);
    run_phase(8, 8);

    drain();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
